// ----- rtl/core/flc_wdd_pkg.sv -----
// ============================================================================
// flc_wdd_pkg
// Types and constants shared by the FLC word-delta (SS2) decoder core.
// ============================================================================
`default_nettype none

package flc_wdd_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_ADDR_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PITCH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH = 1'b1;

    localparam logic [CFG_W-1:0] PITCH_RESET = 13'd320;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd320;

    localparam logic [2:0] KIND_WRITE  = 3'd0;
    localparam logic [2:0] KIND_FILL   = 3'd1;
    localparam logic [2:0] KIND_SINGLE = 3'd2;
    localparam logic [2:0] KIND_DONE   = 3'd3;
    localparam logic [2:0] KIND_BAD    = 3'd4;

    localparam logic [1:0] OP_PACKETS = 2'b00;
    localparam logic [1:0] OP_BAD     = 2'b01;
    localparam logic [1:0] OP_LAST_PX = 2'b10;
    localparam logic [1:0] OP_SKIP    = 2'b11;

    localparam logic [14:0] SKIP_BASE = 15'h4000;
    localparam logic [7:0]  REP_FULL  = 8'd128;

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_OPCODE  = 3'd1,
        PH_PACKET  = 3'd2,
        PH_COPY    = 3'd3,
        PH_FILL    = 3'd4,
        PH_ERROR   = 3'd5,
        PH_PENDING = 3'd6
    } phase_t;

    typedef struct packed {
        logic [15:0] chunk_word;
        logic        chunk_start;
    } in_item_t;

    typedef struct packed {
        logic [2:0]            kind;
        logic [OUT_ADDR_W-1:0] address;
        logic [7:0]            low_byte;
        logic [7:0]            high_byte;
        logic [7:0]            repeat_res;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] line_pitch;
        logic [CFG_W-1:0] line_width;
    } cfg_regs_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } step_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/flc_wdd_cfg.sv -----
// ============================================================================
// flc_wdd_cfg
// Configuration register file: line pitch and line width.
// ============================================================================
`default_nettype none

module flc_wdd_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [flc_wdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [flc_wdd_pkg::CFG_W-1:0]     cfg_data,
    output flc_wdd_pkg::cfg_regs_t                cfg_regs
);
    import flc_wdd_pkg::*;

    logic [CFG_W-1:0] pitch_reg;
    logic [CFG_W-1:0] width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= PITCH_RESET;
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IDX_PITCH: pitch_reg <= cfg_data;
                CFG_IDX_WIDTH: width_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg_regs.line_pitch = pitch_reg;
    assign cfg_regs.line_width = width_reg;

endmodule

`default_nettype wire

// ----- rtl/core/flc_wdd_step.sv -----
// ============================================================================
// flc_wdd_step
// Decoder state and per-word next-state and result logic.
// ============================================================================
`default_nettype none

module flc_wdd_step #(
    parameter int ADDR_BITS = 22
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   fire,
    input  wire flc_wdd_pkg::in_item_t  item,
    input  wire flc_wdd_pkg::cfg_regs_t cfg_regs,
    output flc_wdd_pkg::step_res_t      res
);
    import flc_wdd_pkg::*;

    phase_t                phase_reg,    phase_next;
    logic [15:0]           lines_reg,    lines_next;
    logic [13:0]           packets_reg,  packets_next;
    logic [6:0]            words_reg,    words_next;
    logic [ADDR_BITS-1:0]  base_reg,     base_next;
    logic [ADDR_BITS-1:0]  wp_reg,       wp_next;

    logic [15:0]          w;
    logic                 start;
    logic [1:0]           opcode;
    logic [7:0]           cnt;
    logic [15:0]          lines_dec;
    logic                 line_last;
    logic [13:0]          packets_dec;
    logic                 pkt_last;
    logic [6:0]           words_dec;
    logic [7:0]           fill_rep;
    logic [14:0]          skip_lines;
    logic [27:0]          skip_prod;
    logic [ADDR_BITS-1:0] base_pitch;
    logic [ADDR_BITS-1:0] base_skip;
    logic [ADDR_BITS-1:0] last_px;
    logic [ADDR_BITS-1:0] wp_skip;

    assign w           = item.chunk_word;
    assign start       = item.chunk_start;
    assign opcode      = w[15:14];
    assign cnt         = w[15:8];
    assign lines_dec   = lines_reg - 16'd1;
    assign line_last   = (lines_dec == 16'd0);
    assign packets_dec = packets_reg - 14'd1;
    assign pkt_last    = (packets_dec == 14'd0);
    assign words_dec   = words_reg - 7'd1;
    assign fill_rep    = (words_reg == 7'd0) ? REP_FULL : {1'b0, words_reg};
    assign skip_lines  = SKIP_BASE - {1'b0, w[13:0]};
    assign skip_prod   = skip_lines * cfg_regs.line_pitch;
    assign base_pitch  = base_reg + ADDR_BITS'(cfg_regs.line_pitch);
    assign base_skip   = base_reg + ADDR_BITS'(skip_prod);
    assign last_px     = base_reg + ADDR_BITS'(cfg_regs.line_width) - ADDR_BITS'(1);
    assign wp_skip     = wp_reg + ADDR_BITS'(w[7:0]);

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        lines_next   = lines_reg;
        packets_next = packets_reg;
        words_next   = words_reg;
        base_next    = base_reg;
        wp_next      = wp_reg;
        if (start)
        begin
            lines_next   = w;
            packets_next = '0;
            words_next   = '0;
            base_next    = '0;
            wp_next      = '0;
            if (w != 16'd0)
                phase_next = PH_OPCODE;
            else if (phase_reg != PH_PENDING)
                phase_next = PH_WAIT;
        end
        else
        begin
            unique case (phase_reg)
                PH_PENDING: phase_next = PH_WAIT;
                PH_OPCODE:
                begin
                    unique case (opcode)
                        OP_PACKETS:
                        begin
                            if (w == 16'd0)
                            begin
                                lines_next = lines_dec;
                                base_next  = base_pitch;
                                if (line_last)
                                    phase_next = PH_WAIT;
                            end
                            else
                            begin
                                packets_next = w[13:0];
                                wp_next      = base_reg;
                                phase_next   = PH_PACKET;
                            end
                        end
                        OP_BAD:     phase_next = PH_ERROR;
                        OP_LAST_PX: ;
                        OP_SKIP:    base_next = base_skip;
                        default:    ;
                    endcase
                end
                PH_PACKET:
                begin
                    wp_next = wp_skip;
                    if (cnt == 8'd0)
                    begin
                        packets_next = packets_dec;
                        if (pkt_last)
                        begin
                            lines_next = lines_dec;
                            base_next  = base_pitch;
                            phase_next = line_last ? PH_WAIT : PH_OPCODE;
                        end
                    end
                    else if (!cnt[7])
                    begin
                        words_next = cnt[6:0];
                        phase_next = PH_COPY;
                    end
                    else
                    begin
                        words_next = 7'(8'd0 - cnt);
                        phase_next = PH_FILL;
                    end
                end
                PH_COPY:
                begin
                    wp_next    = wp_reg + ADDR_BITS'(2);
                    words_next = words_dec;
                    if (words_dec == 7'd0)
                    begin
                        packets_next = packets_dec;
                        phase_next   = PH_PACKET;
                        if (pkt_last)
                        begin
                            lines_next = lines_dec;
                            base_next  = base_pitch;
                            phase_next = line_last ? PH_PENDING : PH_OPCODE;
                        end
                    end
                end
                PH_FILL:
                begin
                    wp_next      = wp_reg + ADDR_BITS'({fill_rep, 1'b0});
                    words_next   = '0;
                    packets_next = packets_dec;
                    phase_next   = PH_PACKET;
                    if (pkt_last)
                    begin
                        lines_next = lines_dec;
                        base_next  = base_pitch;
                        phase_next = line_last ? PH_PENDING : PH_OPCODE;
                    end
                end
                default: ;
            endcase
        end
    end

    // result
    always_comb
    begin
        res.valid           = 1'b0;
        res.item.kind       = KIND_DONE;
        res.item.address    = '0;
        res.item.low_byte   = '0;
        res.item.high_byte  = '0;
        res.item.repeat_res = 8'd1;
        if (start)
        begin
            res.valid = (w == 16'd0) || (phase_reg == PH_PENDING);
        end
        else
        begin
            unique case (phase_reg)
                PH_PENDING: res.valid = 1'b1;
                PH_OPCODE:
                begin
                    unique case (opcode)
                        OP_PACKETS: res.valid = (w == 16'd0) && line_last;
                        OP_BAD:
                        begin
                            res.valid     = 1'b1;
                            res.item.kind = KIND_BAD;
                        end
                        OP_LAST_PX:
                        begin
                            res.valid         = 1'b1;
                            res.item.kind     = KIND_SINGLE;
                            res.item.address  = OUT_ADDR_W'(last_px);
                            res.item.low_byte = w[7:0];
                        end
                        OP_SKIP: ;
                        default: ;
                    endcase
                end
                PH_PACKET: res.valid = (cnt == 8'd0) && pkt_last && line_last;
                PH_COPY:
                begin
                    res.valid          = 1'b1;
                    res.item.kind      = KIND_WRITE;
                    res.item.address   = OUT_ADDR_W'(wp_reg);
                    res.item.low_byte  = w[7:0];
                    res.item.high_byte = w[15:8];
                end
                PH_FILL:
                begin
                    res.valid           = 1'b1;
                    res.item.kind       = KIND_FILL;
                    res.item.address    = OUT_ADDR_W'(wp_reg);
                    res.item.low_byte   = w[7:0];
                    res.item.high_byte  = w[15:8];
                    res.item.repeat_res = fill_rep;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            lines_reg   <= '0;
            packets_reg <= '0;
            words_reg   <= '0;
            base_reg    <= '0;
            wp_reg      <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            lines_reg   <= lines_next;
            packets_reg <= packets_next;
            words_reg   <= words_next;
            base_reg    <= base_next;
            wp_reg      <= wp_next;
        end
    end

    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !start && (phase_reg == PH_ERROR) |-> !res.valid)
        else $error("word after bad opcode produced a result");

    a_pending_reports: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (phase_reg == PH_PENDING) |-> res.valid && (res.item.kind == KIND_DONE))
        else $error("pending done report lost");

    a_copy_writes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !start && (phase_reg == PH_COPY) |-> res.valid && (res.item.kind == KIND_WRITE))
        else $error("copy word produced no pair write");

    a_pending_entry: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !start && (phase_reg == PH_OPCODE) |=> phase_reg != PH_PENDING)
        else $error("opcode word entered pending state");

endmodule

`default_nettype wire

// ----- rtl/core/flc_wdd_out_reg.sv -----
// ============================================================================
// flc_wdd_out_reg
// Result register: holds one result beat until the sink takes it.
// ============================================================================
`default_nettype none

module flc_wdd_out_reg (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire flc_wdd_pkg::step_res_t res,
    output logic                        can_load,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output flc_wdd_pkg::out_item_t      out_item
);
    import flc_wdd_pkg::*;

    logic      full_reg,  full_next;
    out_item_t data_reg;

    assign can_load = !full_reg || !out_stall;

    always_comb
    begin
        full_next = full_reg && out_stall;
        if (load && res.valid)
            full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
            data_reg <= res.item;
    end

    assign out_valid = full_reg;
    assign out_item  = data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(load && res.valid && full_reg && out_stall))
        else $error("held result beat overwritten");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load && res.valid |=> out_valid && (out_item == $past(res.item)))
        else $error("loaded result not presented");

    a_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && !out_stall && !(load && res.valid) |=> !out_valid)
        else $error("taken beat presented again");

endmodule

`default_nettype wire

// ----- rtl/core/flc_word_delta_decoder_core.sv -----
// ============================================================================
// flc_word_delta_decoder_core
// FLC word-delta (SS2) chunk decoder: one chunk word in, at most one
// frame-buffer write command or status beat out.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid / in_stall | in_item   (chunk_word, chunk_start)
//   out     | out_valid/out_stall | out_item  (kind, address, bytes, repeat)
//   cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (pitch, width)
//
// One word per cycle while out_stall is low; an input beat goes through the
// input register, then is decoded into the result register.
// The skip-lines multiply and base add sit between those two registers.
// Reset puts the decoder in the wait-for-line-count state with pitch and
// width at 320. A stalled result beat holds the input register, and
// in_stall rises only once that register is full as well.
// ============================================================================
`default_nettype none

module flc_word_delta_decoder_core #(
    parameter int ADDR_BITS = 22
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire flc_wdd_pkg::in_item_t             in_item,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output flc_wdd_pkg::out_item_t                 out_item,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [flc_wdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [flc_wdd_pkg::CFG_W-1:0]     cfg_data
);
    import flc_wdd_pkg::*;

    logic      in_full_reg, in_full_next;
    in_item_t  in_data_reg;
    logic      accept;
    logic      fire;
    logic      can_load;
    cfg_regs_t cfg_regs;
    step_res_t res;

    assign fire     = in_full_reg && can_load;
    assign in_stall = in_full_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
            in_full_next = 1'b1;
        else if (fire)
            in_full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else
            in_full_reg <= in_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_data_reg <= in_item;
    end

    flc_wdd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_regs  (cfg_regs)
    );

    flc_wdd_step #(
        .ADDR_BITS (ADDR_BITS)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (in_data_reg),
        .cfg_regs (cfg_regs),
        .res      (res)
    );

    flc_wdd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    a_fire_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> in_full_reg)
        else $error("decode step without a held word");

    a_accept_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_full_reg && (in_data_reg == $past(in_item)))
        else $error("accepted word not held");

    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_full_reg |-> !in_stall)
        else $error("input stalled with empty register");

endmodule

`default_nettype wire

// ----- tb/tb_flc_word_delta_decoder_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_flc_word_delta_decoder_core
// Self-checking bench for the FLC word-delta (SS2) decoder core. Chunk words
// go in through a queue-fed driver, and each one is decoded by a bit-exact
// behavioral decoder held here. A monitor checks every command beat field by
// field against the oldest predicted command. The stimulus is a directed
// sequence, then random chunks with noise, under four line settings and
// three idling patterns.
// ============================================================================

module tb_flc_word_delta_decoder_core;

    import flc_wdd_pkg::*;

    localparam int ADDR_BITS      = 22;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IDX_PITCH;
    logic [CFG_W-1:0]     cfg_data = '0;

    // decoder state and line settings
    phase_t               dec_phase = PH_WAIT;
    logic [15:0]          lines_left = '0;
    logic [13:0]          packets_left = '0;
    logic [6:0]           words_left = '0;
    logic [ADDR_BITS-1:0] line_base = '0;
    logic [ADDR_BITS-1:0] write_ptr = '0;
    logic [CFG_W-1:0]     pitch_set = PITCH_RESET;
    logic [CFG_W-1:0]     width_set = WIDTH_RESET;

    out_item_t            due_cmds[$];
    out_item_t            due;
    in_item_t             word_q[$];

    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   words_queued = 0;
    int                   words_taken = 0;
    int                   cmds_checked = 0;
    int                   err_count = 0;
    int                   kind_hits[5] = '{default: 0};
    int                   quiet_cycles = 0;

    flc_word_delta_decoder_core #(
        .ADDR_BITS(ADDR_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void push_cmd(input logic [2:0] kind, input logic [ADDR_BITS-1:0] addr,
                                     input logic [7:0] lo, input logic [7:0] hi,
                                     input logic [7:0] rep);
        out_item_t cmd;
        cmd.kind       = kind;
        cmd.address    = addr;
        cmd.low_byte   = lo;
        cmd.high_byte  = hi;
        cmd.repeat_res = rep;
        due_cmds.push_back(cmd);
    endfunction

    function automatic bit close_line();
        lines_left = lines_left - 1'b1;
        line_base  = line_base + pitch_set;
        return lines_left == 0;
    endfunction

    function automatic bit close_packet();
        packets_left = packets_left - 1'b1;
        if (packets_left != 0)
        begin
            dec_phase = PH_PACKET;
            return 1'b0;
        end
        dec_phase = PH_OPCODE;
        return close_line();
    endfunction

    function automatic void decode_word(input in_item_t it);
        logic [15:0] w;
        logic [7:0]  cnt;
        logic [7:0]  rep;
        bit          was_pending;
        w = it.chunk_word;
        if (it.chunk_start)
        begin
            was_pending  = (dec_phase == PH_PENDING);
            lines_left   = w;
            packets_left = '0;
            words_left   = '0;
            line_base    = '0;
            write_ptr    = '0;
            if (w == 0)
            begin
                dec_phase = was_pending ? PH_PENDING : PH_WAIT;
                push_cmd(KIND_DONE, '0, '0, '0, 8'd1);
            end
            else
            begin
                dec_phase = PH_OPCODE;
                if (was_pending)
                    push_cmd(KIND_DONE, '0, '0, '0, 8'd1);
            end
            return;
        end
        case (dec_phase)
            PH_PENDING:
            begin
                dec_phase = PH_WAIT;
                push_cmd(KIND_DONE, '0, '0, '0, 8'd1);
            end
            PH_OPCODE:
            begin
                case (w[15:14])
                    OP_PACKETS:
                    begin
                        if (w == 0)
                        begin
                            if (close_line())
                            begin
                                dec_phase = PH_WAIT;
                                push_cmd(KIND_DONE, '0, '0, '0, 8'd1);
                            end
                        end
                        else
                        begin
                            packets_left = w[13:0];
                            write_ptr    = line_base;
                            dec_phase    = PH_PACKET;
                        end
                    end
                    OP_BAD:
                    begin
                        dec_phase = PH_ERROR;
                        push_cmd(KIND_BAD, '0, '0, '0, 8'd1);
                    end
                    OP_LAST_PX:
                        push_cmd(KIND_SINGLE, line_base + width_set - 1'b1, w[7:0], '0, 8'd1);
                    default:
                        line_base = line_base + (17'h10000 - w) * pitch_set;
                endcase
            end
            PH_PACKET:
            begin
                cnt       = w[15:8];
                write_ptr = write_ptr + w[7:0];
                if (cnt == 0)
                begin
                    if (close_packet())
                    begin
                        dec_phase = PH_WAIT;
                        push_cmd(KIND_DONE, '0, '0, '0, 8'd1);
                    end
                end
                else if (!cnt[7])
                begin
                    words_left = cnt[6:0];
                    dec_phase  = PH_COPY;
                end
                else
                begin
                    words_left = 7'(8'h00 - cnt);
                    dec_phase  = PH_FILL;
                end
            end
            PH_COPY:
            begin
                push_cmd(KIND_WRITE, write_ptr, w[7:0], w[15:8], 8'd1);
                write_ptr  = write_ptr + 2'd2;
                words_left = words_left - 1'b1;
                if (words_left == 0)
                    if (close_packet())
                        dec_phase = PH_PENDING;
            end
            PH_FILL:
            begin
                rep = (words_left == 0) ? REP_FULL : {1'b0, words_left};
                push_cmd(KIND_FILL, write_ptr, w[7:0], w[15:8], rep);
                write_ptr  = write_ptr + ADDR_BITS'({rep, 1'b0});
                words_left = '0;
                if (close_packet())
                    dec_phase = PH_PENDING;
            end
            default:
            begin
            end
        endcase
    endfunction

    // input driver: hold the beat while stalled, advance when taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_word(in_item);
                words_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_item  <= word_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_cmds.size() == 0)
                begin
                    $error("result beat with nothing expected: kind %0d", out_item.kind);
                    err_count++;
                end
                else
                begin
                    due = due_cmds.pop_front();
                    cmds_checked++;
                    if (out_item.kind < 5)
                        kind_hits[out_item.kind]++;
                    if (out_item.kind !== due.kind)
                    begin
                        $error("kind: expected %0d, got %0d", due.kind, out_item.kind);
                        err_count++;
                    end
                    if (out_item.address !== due.address)
                    begin
                        $error("address: expected %h, got %h", due.address, out_item.address);
                        err_count++;
                    end
                    if (out_item.low_byte !== due.low_byte)
                    begin
                        $error("low_byte: expected %h, got %h", due.low_byte, out_item.low_byte);
                        err_count++;
                    end
                    if (out_item.high_byte !== due.high_byte)
                    begin
                        $error("high_byte: expected %h, got %h", due.high_byte,
                               out_item.high_byte);
                        err_count++;
                    end
                    if (out_item.repeat_res !== due.repeat_res)
                    begin
                        $error("repeat_res: expected %0d, got %0d", due.repeat_res,
                               out_item.repeat_res);
                        err_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog: drop the run after too long without any beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: %0d commands still expected", due_cmds.size());
                $display("DONE: errors detected");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_word(input logic [15:0] w, input logic s);
        in_item_t it;
        it.chunk_word  = w;
        it.chunk_start = s;
        word_q.push_back(it);
        words_queued++;
    endtask

    task automatic queue_chunk();
        int         lines;
        int         n_pk;
        int         span;
        int         skip;
        int         pick;
        logic [7:0] cnt;
        lines = $urandom_range(1, 4);
        if ($urandom_range(9) == 0)
            lines = 0;
        else if ($urandom_range(19) == 0)
            lines = $urandom_range(5, 16'hFFFF);
        queue_word(16'(lines), 1'b1);
        for (int l = 0; l < lines && l < 4; l++)
        begin
            if ($urandom_range(3) == 0)
            begin
                skip = ($urandom_range(7) == 0) ? $urandom_range(1, 16'h4000)
                                                : $urandom_range(1, 3);
                queue_word(16'(17'h10000 - skip), 1'b0);
            end
            if ($urandom_range(3) == 0)
                queue_word({OP_LAST_PX, 14'($urandom)}, 1'b0);
            if ($urandom_range(39) == 0)
            begin
                queue_word({OP_BAD, 14'($urandom)}, 1'b0);
                return;
            end
            n_pk = $urandom_range(0, 3);
            if (n_pk == 0)
                queue_word({OP_PACKETS, 14'd0}, 1'b0);
            else if ($urandom_range(29) == 0)
                queue_word({OP_PACKETS, 14'($urandom)}, 1'b0);
            else
                queue_word({OP_PACKETS, 14'(n_pk)}, 1'b0);
            for (int p = 0; p < n_pk; p++)
            begin
                if ($urandom_range(59) == 0)
                    return;
                pick = $urandom_range(9);
                span = ($urandom_range(7) == 0) ? $urandom_range(5, 127) : $urandom_range(1, 4);
                if (pick == 0)
                begin
                    cnt  = 8'd0;
                    span = 0;
                end
                else if (pick < 6)
                    cnt = 8'(span);
                else
                begin
                    if (pick == 9)
                        span = 128;
                    cnt  = 8'(256 - span);
                    span = 1;
                end
                queue_word({cnt, 8'($urandom)}, 1'b0);
                repeat (span)
                    queue_word(16'($urandom), 1'b0);
            end
        end
    endtask

    task automatic queue_random(input int n_words);
        int goal;
        goal = words_queued + n_words;
        while (words_queued < goal)
        begin
            if ($urandom_range(99) < 85)
                queue_chunk();
            else
                queue_word(16'($urandom), $urandom_range(7) == 0);
        end
    endtask

    task automatic settle();
        while (word_q.size() != 0 || in_valid || due_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_IDX_PITCH)
            pitch_set = val;
        else
            width_set = val;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 21;
        recv_idle_pct = 68;

        // directed sequence at reset line settings
        queue_word(16'h0000, 1'b1);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'h0002, 1'b1);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'h80AB, 1'b0);
        queue_word(16'h0002, 1'b0);
        queue_word(16'h0205, 1'b0);
        queue_word(16'h1234, 1'b0);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'h8010, 1'b0);
        queue_word(16'hA55A, 1'b0);
        queue_word(16'h0000, 1'b0);
        queue_word(16'h1111, 1'b0);
        queue_word(16'h0001, 1'b1);
        queue_word(16'h0001, 1'b0);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'h00FF, 1'b0);
        queue_word(16'h0000, 1'b1);
        queue_word(16'h0001, 1'b1);
        queue_word(16'h0000, 1'b0);
        queue_word(16'hFFFF, 1'b1);
        queue_word(16'hC000, 1'b0);
        queue_word(16'h0001, 1'b0);
        queue_word(16'h0000, 1'b0);
        queue_word(16'h4000, 1'b0);
        queue_word(16'h3FFF, 1'b0);
        settle();

        write_reg(CFG_IDX_PITCH, 13'd4096);
        write_reg(CFG_IDX_WIDTH, 13'd1);
        queue_random(130);
        settle();

        send_idle_pct = 68;
        recv_idle_pct = 21;
        write_reg(CFG_IDX_PITCH, 13'd1);
        write_reg(CFG_IDX_WIDTH, 13'd4096);
        queue_random(130);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_IDX_PITCH, 13'h1FFF);
        write_reg(CFG_IDX_WIDTH, 13'd0);
        queue_random(130);
        settle();

        $display("covered %0d chunk words and %0d commands under four line settings",
                 words_taken, cmds_checked);
        $display("commands by kind: %0d write, %0d fill, %0d single, %0d done, %0d bad",
                 kind_hits[KIND_WRITE], kind_hits[KIND_FILL], kind_hits[KIND_SINGLE],
                 kind_hits[KIND_DONE], kind_hits[KIND_BAD]);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- flc_word_delta_decoder_core.f -----
rtl/core/flc_wdd_pkg.sv
rtl/core/flc_wdd_cfg.sv
rtl/core/flc_wdd_step.sv
rtl/core/flc_wdd_out_reg.sv
rtl/core/flc_word_delta_decoder_core.sv
tb/tb_flc_word_delta_decoder_core.sv
